FILE: design/gmto_pkg.sv
package gmto_pkg;

  localparam int SCREEN_WIDTH  = 64;
  localparam int SCREEN_HEIGHT = 64;
  localparam int PAD           = 2;

  localparam int MASK_W = 64;
  localparam int ROW_W  = 6;
  localparam int CNT_W  = $clog2(SCREEN_HEIGHT);
  localparam int WIN    = 2 * PAD + 1;
  localparam int PAD_W  = MASK_W + 2 * PAD;

  localparam logic [MASK_W-1:0] COL_MASK = {MASK_W{1'b1}} >> (MASK_W - SCREEN_WIDTH);

  typedef logic [MASK_W-1:0] mask_t;
  typedef logic [CNT_W-1:0]  cnt_t;

  // rows[0] is the top row of the window, rows[WIN-1] the bottom
  typedef struct packed {
    mask_t [WIN-1:0] rows;
    cnt_t            row;
    logic            last;
  } job_t;

  // one column's neighborhood, [row][column offset]
  typedef logic [WIN-1:0][WIN-1:0] lane_win_t;

  typedef struct packed {
    logic text;
    logic inner;
    logic outer;
  } lane_class_t;

endpackage

FILE: design/gmto_if.sv
interface gmto_in_if;
  import gmto_pkg::*;

  logic  valid;
  logic  ready;
  mask_t mask_row;

  modport source (output valid, output mask_row, input ready);
  modport sink   (input valid, input mask_row, output ready);
endinterface

interface gmto_out_if;
  import gmto_pkg::*;

  logic             valid;
  logic             ready;
  logic [ROW_W-1:0] row_index;
  mask_t            text_bits;
  mask_t            inner_ring_bits;
  mask_t            outer_ring_bits;
  logic             frame_done;

  modport source (output valid, output row_index, output text_bits,
                  output inner_ring_bits, output outer_ring_bits,
                  output frame_done, input ready);
  modport sink   (input valid, input row_index, input text_bits,
                  input inner_ring_bits, input outer_ring_bits,
                  input frame_done, output ready);
endinterface

FILE: design/glyph_mask_two_ring_outline_core.sv
// Streams a binary text mask one row per request, in raster order, and returns for each
// row three masks: glyph pixels, clear pixels at Chebyshev distance one from glyph, and
// clear pixels at distance exactly two. Pixels off the screen count as clear. A result
// for row r-2 is registered in the output register when row r is accepted, so rows
// 0 and 1 of a frame give no result and the bottom row gives three (rows H-3, H-2,
// H-1, the last with frame_done set). One row is accepted per cycle while the output
// register is free and no flush is running; after the bottom row of a frame the input
// is held off while the single output register sends the two flushed results. One
// lane per column classifies its 5x5 neighborhood.
module glyph_mask_two_ring_outline_core (
  input  logic       clk,
  input  logic       rst,
  gmto_in_if.sink    rows,
  gmto_out_if.source results
);
  import gmto_pkg::*;

  logic  job_valid;
  job_t  job;
  logic  out_free;

  mask_t [WIN-1:0] padded_unused_guard;
  logic  [WIN-1:0][PAD_W-1:0] padded;
  mask_t text_m;
  mask_t inner_m;
  mask_t outer_m;

  assign out_free = !results.valid || results.ready;

  gmto_window u_window (
    .clk       (clk),
    .rst       (rst),
    .rows      (rows),
    .out_free  (out_free),
    .job_valid (job_valid),
    .job       (job)
  );

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      padded_unused_guard[k] = job.rows[k] & COL_MASK;
      padded[k] = {{PAD{1'b0}}, padded_unused_guard[k], {PAD{1'b0}}};
    end
  end

  for (genvar c = 0; c < MASK_W; c++) begin : g_lane
    if (c < SCREEN_WIDTH) begin : g_on
      lane_win_t   win;
      lane_class_t cls;

      always_comb begin
        for (int k = 0; k < WIN; k++) begin
          win[k] = padded[k][c +: WIN];
        end
      end

      gmto_lane u_lane (
        .win (win),
        .cls (cls)
      );

      assign text_m[c]  = cls.text;
      assign inner_m[c] = cls.inner;
      assign outer_m[c] = cls.outer;
    end else begin : g_off
      assign text_m[c]  = 1'b0;
      assign inner_m[c] = 1'b0;
      assign outer_m[c] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_free) begin
      results.valid <= job_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && job_valid) begin
      results.row_index       <= ROW_W'(job.row);
      results.text_bits       <= text_m;
      results.inner_ring_bits <= inner_m;
      results.outer_ring_bits <= outer_m;
      results.frame_done      <= job.last;
    end
  end

endmodule

FILE: design/gmto_lane.sv
module gmto_lane (
  input  gmto_pkg::lane_win_t   win,
  output gmto_pkg::lane_class_t cls
);
  import gmto_pkg::*;

  logic near1;
  logic near2;

  always_comb begin
    near1 = 1'b0;
    near2 = 1'b0;
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN; c++) begin
        near2 = near2 | win[r][c];
        if (r >= PAD - 1 && r <= PAD + 1 && c >= PAD - 1 && c <= PAD + 1) begin
          near1 = near1 | win[r][c];
        end
      end
    end
    cls.text  = win[PAD][PAD];
    cls.inner = near1 & ~win[PAD][PAD];
    cls.outer = near2 & ~near1;
  end

endmodule

FILE: design/gmto_window.sv
module gmto_window (
  input  logic           clk,
  input  logic           rst,
  gmto_in_if.sink        rows,
  input  logic           out_free,
  output logic           job_valid,
  output gmto_pkg::job_t job
);
  import gmto_pkg::*;

  mask_t [WIN-2:0] window;
  cnt_t            cnt;
  logic [1:0]      flush_left;

  mask_t cur;
  logic  accept;
  logic  flushing;
  logic  frame_end;

  assign cur       = rows.mask_row & COL_MASK;
  assign flushing  = (flush_left != 2'd0);
  assign rows.ready = !flushing && out_free;
  assign accept    = rows.valid && rows.ready;
  assign frame_end = (cnt == CNT_W'(SCREEN_HEIGHT - 1));

  always_comb begin
    for (int k = 0; k < WIN - 1; k++) begin
      job.rows[k] = window[k];
    end
    job.rows[WIN-1] = flushing ? '0 : cur;
    job.last = (flush_left == 2'd1);
    priority if (flush_left == 2'd2) begin
      job.row = cnt - CNT_W'(1);
    end else if (flush_left == 2'd1) begin
      job.row = cnt;
    end else begin
      job.row = cnt - CNT_W'(2);
    end
    job_valid = flushing ? out_free : (accept && cnt >= CNT_W'(2));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window     <= '0;
      cnt        <= '0;
      flush_left <= 2'd0;
    end else if (accept) begin
      for (int k = 0; k < WIN - 2; k++) begin
        window[k] <= window[k+1];
      end
      window[WIN-2] <= cur;
      if (frame_end) begin
        flush_left <= 2'd2;
      end else begin
        cnt <= cnt + CNT_W'(1);
      end
    end else if (flushing && out_free) begin
      if (flush_left == 2'd2) begin
        // rows below the screen shift in as clear
        for (int k = 0; k < WIN - 2; k++) begin
          window[k] <= window[k+1];
        end
        window[WIN-2] <= '0;
        flush_left    <= 2'd1;
      end else begin
        window     <= '0;
        cnt        <= '0;
        flush_left <= 2'd0;
      end
    end
  end

endmodule
